@@ src/spr_pkg.sv @@
package spr_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 6;
    localparam int SLOT_BYTES   = 6;
    localparam int MAX_SLOTS    = 1024;
    localparam int TOMB_SHIFT   = 2;   // tombstone threshold: a quarter of the slots

    localparam int OFF_W  = $clog2(PAGE_BYTES + 1);   // offsets, lengths, byte counts
    localparam int PG_AW  = $clog2(PAGE_BYTES);       // page memory address
    localparam int SLOT_W = $clog2(MAX_SLOTS);        // slot index
    localparam int CNT_W  = SLOT_W + 1;               // slot count
    localparam int SA_W   = SLOT_W + 1;               // slot memory address incl. bank

    localparam logic [OFF_W-1:0] PAGE_END    = OFF_W'(PAGE_BYTES);
    localparam logic [OFF_W-1:0] HEADER_END  = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] SLOT_SIZE   = OFF_W'(SLOT_BYTES);
    localparam logic [CNT_W-1:0] SLOTS_LIMIT = CNT_W'(MAX_SLOTS);

    typedef enum logic [2:0] {
        K_RESET   = 3'd0,
        K_INSERT  = 3'd1,
        K_WRITE   = 3'd2,
        K_READ    = 3'd3,
        K_DELETE  = 3'd4,
        K_UPDATE  = 3'd5,
        K_COMPACT = 3'd6,
        K_QUERY   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_IDX  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_UPD1,
        S_UPD2,
        S_UPD3,
        S_C_RDL,
        S_C_RDS,
        S_C_EVAL,
        S_MV_RD,
        S_MV_WR,
        S_C_NEXT,
        S_C_FIN,
        S_RETRY,
        S_RESULT
    } state_t;

    // slot entry; walk is the slot id at this entry's place in allocation order,
    // pos is this slot's own place in that order
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [OFF_W-1:0]  length;
        logic              deleted;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] walk;
    } slot_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  slot_number;
        logic [12:0] record_length;
        logic [11:0] byte_index;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_out;
        logic [7:0]  data_out;
        logic [10:0] live_records;
        logic [10:0] slot_count;
        logic [12:0] contiguous_free;
        logic        needs_compaction;
    } result_t;

endpackage

@@ src/spr_item_if.sv @@
interface spr_item_if;
    import spr_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/spr_result_if.sv @@
interface spr_result_if;
    import spr_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/slotted_page_record_store.sv @@
// Slotted-page record store: one page of records with a slot directory.
// cmd takes one operation per transfer (reset page, insert, write byte, read
// byte, delete, update, compact, status query); res returns exactly one result
// per operation with status, assigned slot, read byte and the page counters.
// cfg_write_en / cfg_write_data set the auto-compaction flag (1 after reset).
// A byte read waits for the page memory read; an update that moves the record
// writes slot entries in S_UPD1, S_UPD2 and S_UPD3. Compaction (explicit, or
// an insert that fails with auto-compaction on and enough total free space)
// walks the slots in allocation order and slides each live record up byte by
// byte; the failed insert is then retried once after it.
// One operation is in flight at a time: cmd is ready only in the idle state.
// Record bytes and slot entries live in two synchronous memories with one read
// and one write port; the slot memory has two banks, compaction copies from
// one into the other.
// Reset clears the counters and flags only; memories are not cleared.
// A result waits in the output register while res is stalled; the next cmd
// may be taken meanwhile, and its result is held back until res drains.
module slotted_page_record_store (
    input  logic               clk,
    input  logic               rst_n,
    spr_item_if.sink           cmd,
    spr_result_if.source       res,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data
);
    import spr_pkg::*;

    // memories
    logic [7:0]   page_mem [PAGE_BYTES];
    slot_entry_t  slot_mem [2*MAX_SLOTS];

    logic             pg_we;
    logic [PG_AW-1:0] pg_waddr;
    logic [PG_AW-1:0] pg_raddr;
    logic [7:0]       pg_wdata;
    logic [7:0]       pg_rdata;

    logic             sm_we;
    logic [SA_W-1:0]  sm_waddr;
    logic [SA_W-1:0]  sm_raddr;
    slot_entry_t      sm_wdata;
    slot_entry_t      sm_rdata;

    // control and page state
    state_t            state_reg, state_next;
    logic              cur_reg, cur_next;
    logic              auto_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  tomb_reg, tomb_next;
    logic [OFF_W-1:0]  delb_reg, delb_next;
    logic [OFF_W-1:0]  fs_reg, fs_next;
    logic [OFF_W-1:0]  fe_reg, fe_next;
    logic              retry_reg, retry_next;
    logic              out_valid_reg, out_valid_next;

    // compaction walk
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [OFF_W-1:0]  lfs_reg, lfs_next;
    logic [OFF_W-1:0]  gap_reg, gap_next;
    logic [OFF_W-1:0]  last_reg, last_next;
    logic [PG_AW-1:0]  mv_i_reg, mv_i_next;
    logic [OFF_W-1:0]  mv_src_reg, mv_src_next;
    logic [OFF_W-1:0]  mv_dst_reg, mv_dst_next;

    // payload registers
    item_t             item_reg, item_next;
    slot_entry_t       ent_reg, ent_next;
    logic [1:0]        rs_status_reg, rs_status_next;
    logic [SLOT_W-1:0] rs_slot_reg, rs_slot_next;
    logic [7:0]        rs_data_reg, rs_data_next;
    result_t           out_reg, out_next;

    // derived values
    logic [OFF_W-1:0]  contig;
    logic [OFF_W:0]    total_space;
    logic [OFF_W:0]    need_space;
    logic [OFF_W-1:0]  res_start;
    logic              res_fail;
    logic              slot_live;
    logic [OFF_W:0]    byte_addr;
    logic [SLOT_W-1:0] sn;
    logic [SLOT_W-1:0] n_idx;
    logic [SLOT_W-1:0] p_idx;
    slot_entry_t       p_ent;
    logic [OFF_W-1:0]  dst;

    assign sn     = item_reg.slot_number;
    assign n_idx  = used_reg[SLOT_W-1:0];
    assign contig = (fe_reg >= fs_reg) ? fe_reg - fs_reg : '0;
    assign total_space = {1'b0, contig} + {1'b0, delb_reg};
    assign need_space  = {1'b0, item_reg.record_length} + {1'b0, SLOT_SIZE};
    assign res_start   = fe_reg - item_reg.record_length;
    assign res_fail    = (used_reg >= SLOTS_LIMIT) || (item_reg.record_length > fe_reg)
                      || (({1'b0, fs_reg} + {1'b0, SLOT_SIZE}) >= {1'b0, res_start});
    assign slot_live   = ({1'b0, sn} < used_reg) && !sm_rdata.deleted;
    assign byte_addr   = {1'b0, sm_rdata.offset} + (OFF_W+1)'(item_reg.byte_index);
    assign p_idx       = ent_reg.pos;
    assign p_ent       = (p_idx == sn) ? ent_reg : sm_rdata;
    assign dst         = sm_rdata.offset + gap_reg;

    assign cmd.ready   = (state_reg == S_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_waddr] <= pg_wdata;
        end
        pg_rdata <= page_mem[pg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            slot_mem[sm_waddr] <= sm_wdata;
        end
        sm_rdata <= slot_mem[sm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= 1'b0;
            auto_reg      <= 1'b1;
            used_reg      <= '0;
            tomb_reg      <= '0;
            delb_reg      <= '0;
            fs_reg        <= HEADER_END;
            fe_reg        <= PAGE_END;
            retry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            live_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            if (cfg_write_en)
            begin
                auto_reg <= cfg_write_data;
            end
            used_reg      <= used_next;
            tomb_reg      <= tomb_next;
            delb_reg      <= delb_next;
            fs_reg        <= fs_next;
            fe_reg        <= fe_next;
            retry_reg     <= retry_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lfs_reg       <= lfs_next;
        gap_reg       <= gap_next;
        last_reg      <= last_next;
        mv_i_reg      <= mv_i_next;
        mv_src_reg    <= mv_src_next;
        mv_dst_reg    <= mv_dst_next;
        item_reg      <= item_next;
        ent_reg       <= ent_next;
        rs_status_reg <= rs_status_next;
        rs_slot_reg   <= rs_slot_next;
        rs_data_reg   <= rs_data_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        tomb_next      = tomb_reg;
        delb_next      = delb_reg;
        fs_next        = fs_reg;
        fe_next        = fe_reg;
        retry_next     = retry_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        live_next      = live_reg;
        lfs_next       = lfs_reg;
        gap_next       = gap_reg;
        last_next      = last_reg;
        mv_i_next      = mv_i_reg;
        mv_src_next    = mv_src_reg;
        mv_dst_next    = mv_dst_reg;
        item_next      = item_reg;
        ent_next       = ent_reg;
        rs_status_next = rs_status_reg;
        rs_slot_next   = rs_slot_reg;
        rs_data_next   = rs_data_reg;
        out_next       = out_reg;

        pg_we    = 1'b0;
        pg_waddr = '0;
        pg_wdata = '0;
        pg_raddr = '0;
        sm_we    = 1'b0;
        sm_waddr = '0;
        sm_wdata = '0;
        sm_raddr = '0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                sm_raddr = {cur_reg, cmd.payload.slot_number};
                if (cmd.valid)
                begin
                    item_next      = cmd.payload;
                    rs_status_next = ST_OK;
                    rs_slot_next   = '0;
                    rs_data_next   = '0;
                    retry_next     = 1'b0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESULT;
                case (kind_t'(item_reg.kind))
                    K_RESET:
                    begin
                        used_next = '0;
                        tomb_next = '0;
                        delb_next = '0;
                        fs_next   = HEADER_END;
                        fe_next   = PAGE_END;
                    end
                    K_INSERT:
                    begin
                        if (!res_fail)
                        begin
                            sm_we        = 1'b1;
                            sm_waddr     = {cur_reg, n_idx};
                            sm_wdata     = '{res_start, item_reg.record_length, 1'b0,
                                             n_idx, n_idx};
                            used_next    = used_reg + 1'b1;
                            fs_next      = fs_reg + SLOT_SIZE;
                            fe_next      = res_start;
                            rs_slot_next = n_idx;
                        end
                        else
                        begin
                            rs_status_next = ST_NO_SPACE;
                            if (auto_reg && (need_space <= total_space))
                            begin
                                retry_next = 1'b1;
                                k_next     = '0;
                                live_next  = '0;
                                lfs_next   = HEADER_END;
                                gap_next   = '0;
                                last_next  = PAGE_END;
                                state_next = (used_reg == '0) ? S_C_FIN : S_C_RDL;
                            end
                        end
                    end
                    K_WRITE, K_READ:
                    begin
                        if (!slot_live)
                        begin
                            rs_status_next = ST_NO_SLOT;
                        end
                        else if ({1'b0, item_reg.byte_index} >= sm_rdata.length)
                        begin
                            rs_status_next = ST_BAD_IDX;
                        end
                        else if (byte_addr < (OFF_W+1)'(PAGE_BYTES))
                        begin
                            if (item_reg.kind == K_WRITE)
                            begin
                                pg_we    = 1'b1;
                                pg_waddr = byte_addr[PG_AW-1:0];
                                pg_wdata = item_reg.data_byte;
                            end
                            else
                            begin
                                pg_raddr   = byte_addr[PG_AW-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                    end
                    K_DELETE:
                    begin
                        if (!slot_live)
                        begin
                            rs_status_next = ST_NO_SLOT;
                        end
                        else
                        begin
                            sm_we            = 1'b1;
                            sm_waddr         = {cur_reg, sn};
                            sm_wdata         = sm_rdata;
                            sm_wdata.deleted = 1'b1;
                            tomb_next        = tomb_reg + 1'b1;
                            delb_next        = delb_reg + sm_rdata.length;
                        end
                    end
                    K_UPDATE:
                    begin
                        if (!slot_live)
                        begin
                            rs_status_next = ST_NO_SLOT;
                        end
                        else if (item_reg.record_length > sm_rdata.length)
                        begin
                            if (res_fail)
                            begin
                                rs_status_next = ST_NO_SPACE;
                            end
                            else
                            begin
                                ent_next   = sm_rdata;
                                sm_raddr   = {cur_reg, sm_rdata.pos};
                                state_next = S_UPD1;
                            end
                        end
                    end
                    K_COMPACT:
                    begin
                        k_next     = '0;
                        live_next  = '0;
                        lfs_next   = HEADER_END;
                        gap_next   = '0;
                        last_next  = PAGE_END;
                        state_next = (used_reg == '0) ? S_C_FIN : S_C_RDL;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_RDWAIT:
            begin
                rs_data_next = pg_rdata;
                state_next   = S_RESULT;
            end

            // longer update: the tombstone takes the old place in allocation order
            S_UPD1:
            begin
                sm_we         = 1'b1;
                sm_waddr      = {cur_reg, p_idx};
                sm_wdata      = p_ent;
                sm_wdata.walk = n_idx;
                state_next    = S_UPD2;
            end

            S_UPD2:
            begin
                sm_we      = 1'b1;
                sm_waddr   = {cur_reg, sn};
                sm_wdata   = '{res_start, item_reg.record_length, 1'b0, n_idx,
                               (p_idx == sn) ? n_idx : ent_reg.walk};
                state_next = S_UPD3;
            end

            S_UPD3:
            begin
                sm_we      = 1'b1;
                sm_waddr   = {cur_reg, n_idx};
                sm_wdata   = '{ent_reg.offset, ent_reg.length, 1'b1, ent_reg.pos, sn};
                tomb_next  = tomb_reg + 1'b1;
                delb_next  = delb_reg + ent_reg.length;
                used_next  = used_reg + 1'b1;
                fs_next    = fs_reg + SLOT_SIZE;
                fe_next    = res_start;
                state_next = S_RESULT;
            end

            S_C_RDL:
            begin
                sm_raddr   = {cur_reg, k_reg[SLOT_W-1:0]};
                state_next = S_C_RDS;
            end

            S_C_RDS:
            begin
                sm_raddr   = {cur_reg, sm_rdata.walk};
                state_next = S_C_EVAL;
            end

            S_C_EVAL:
            begin
                state_next = S_C_NEXT;
                if (sm_rdata.deleted)
                begin
                    gap_next = gap_reg + sm_rdata.length;
                end
                else
                begin
                    sm_we     = 1'b1;
                    sm_waddr  = {~cur_reg, live_reg[SLOT_W-1:0]};
                    sm_wdata  = '{dst, sm_rdata.length, 1'b0,
                                  live_reg[SLOT_W-1:0], live_reg[SLOT_W-1:0]};
                    live_next = live_reg + 1'b1;
                    lfs_next  = lfs_reg + SLOT_SIZE;
                    last_next = dst;
                    if ((gap_reg != '0) && (sm_rdata.length != '0))
                    begin
                        mv_src_next = sm_rdata.offset;
                        mv_dst_next = dst;
                        mv_i_next   = PG_AW'(sm_rdata.length - 1'b1);
                        state_next  = S_MV_RD;
                    end
                end
            end

            // slide bytes up, top byte first, so the source is never overwritten
            S_MV_RD:
            begin
                pg_raddr   = PG_AW'(mv_src_reg + OFF_W'(mv_i_reg));
                state_next = S_MV_WR;
            end

            S_MV_WR:
            begin
                pg_we    = 1'b1;
                pg_waddr = PG_AW'(mv_dst_reg + OFF_W'(mv_i_reg));
                pg_wdata = pg_rdata;
                if (mv_i_reg == '0)
                begin
                    state_next = S_C_NEXT;
                end
                else
                begin
                    mv_i_next  = mv_i_reg - 1'b1;
                    state_next = S_MV_RD;
                end
            end

            S_C_NEXT:
            begin
                k_next     = k_reg + 1'b1;
                state_next = ((k_reg + 1'b1) == used_reg) ? S_C_FIN : S_C_RDL;
            end

            S_C_FIN:
            begin
                cur_next   = ~cur_reg;
                used_next  = live_reg;
                tomb_next  = '0;
                delb_next  = '0;
                fs_next    = lfs_reg;
                fe_next    = last_reg;
                state_next = retry_reg ? S_RETRY : S_RESULT;
            end

            S_RETRY:
            begin
                state_next = S_RESULT;
                if (!res_fail)
                begin
                    sm_we          = 1'b1;
                    sm_waddr       = {cur_reg, n_idx};
                    sm_wdata       = '{res_start, item_reg.record_length, 1'b0,
                                       n_idx, n_idx};
                    used_next      = used_reg + 1'b1;
                    fs_next        = fs_reg + SLOT_SIZE;
                    fe_next        = res_start;
                    rs_slot_next   = n_idx;
                    rs_status_next = ST_OK;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_next.status           = rs_status_reg;
                    out_next.slot_out         = rs_slot_reg;
                    out_next.data_out         = rs_data_reg;
                    out_next.live_records     = used_reg - tomb_reg;
                    out_next.slot_count       = used_reg;
                    out_next.contiguous_free  = contig;
                    out_next.needs_compaction = (used_reg != '0)
                                             && (tomb_reg > (used_reg >> TOMB_SHIFT));
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // slot directory always ends where the slot count says
    assert property (@(posedge clk) disable iff (!rst_n)
        fs_reg == OFF_W'(HEADER_BYTES + int'(used_reg) * SLOT_BYTES))
        else $error("free start out of step with slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tomb_reg <= used_reg) && (used_reg <= SLOTS_LIMIT))
        else $error("tombstone or slot count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        fe_reg >= fs_reg)
        else $error("record area overlaps slot directory");

    // a byte move only happens for a record that actually slides up
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MV_WR) |-> (gap_reg != '0) && (mv_dst_reg > mv_src_reg))
        else $error("compaction move without upward gap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_FIN) |=> (tomb_reg == '0) && (delb_reg == '0))
        else $error("compaction left tombstones behind");

endmodule

@@ bench/slotted_page_record_store_tb.sv @@
module slotted_page_record_store_tb;
    import spr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 100;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    spr_item_if   cmd ();
    spr_result_if res ();

    slotted_page_record_store dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd.sink),
        .res            (res.source),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // page shadow: slot directory, record bytes and which bytes hold written data
    int unsigned rec_off [MAX_SLOTS];
    int unsigned rec_len [MAX_SLOTS];
    bit          rec_dead [MAX_SLOTS];
    logic [7:0]  page_byte [PAGE_BYTES];
    bit          page_known [PAGE_BYTES];
    int unsigned n_slots;
    int unsigned n_tombs;
    int unsigned dead_bytes;
    int unsigned fs_ptr;
    int unsigned fe_ptr;
    bit          auto_cmp;

    result_t     expected_q [$];
    int unsigned err_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned compactions;
    int unsigned idle_cycles;
    bit          sender_busy_free;
    bit          receiver_busy_free;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic void page_clear();
        n_slots    = 0;
        n_tombs    = 0;
        dead_bytes = 0;
        fs_ptr     = HEADER_BYTES;
        fe_ptr     = PAGE_BYTES;
        for (int a = 0; a < PAGE_BYTES; a++)
            page_known[a] = 1'b0;
    endfunction

    function automatic bit slot_is_live(int unsigned s);
        return s < n_slots && !rec_dead[s];
    endfunction

    function automatic bit find_space(int unsigned len, output int unsigned start);
        int unsigned slot_end;
        start = 0;
        if (n_slots >= MAX_SLOTS || len > fe_ptr)
            return 1'b0;
        slot_end = HEADER_BYTES + (n_slots + 1) * SLOT_BYTES;
        if (slot_end >= fe_ptr - len)
            return 1'b0;
        start = fe_ptr - len;
        for (int a = start; a < start + len; a++)
            page_known[a] = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit place_record(int unsigned len, output int unsigned slot);
        int unsigned start;
        slot = 0;
        if (!find_space(len, start))
            return 1'b0;
        rec_off[n_slots]  = start;
        rec_len[n_slots]  = len;
        rec_dead[n_slots] = 1'b0;
        slot = n_slots;
        n_slots++;
        fs_ptr = HEADER_BYTES + n_slots * SLOT_BYTES;
        fe_ptr = start;
        return 1'b1;
    endfunction

    function automatic bit walk_first(int unsigned a, int unsigned b);
        int unsigned ea, eb;
        ea = rec_off[a] + rec_len[a];
        eb = rec_off[b] + rec_len[b];
        if (rec_off[a] != rec_off[b])
            return rec_off[a] > rec_off[b];
        if (ea != eb)
            return ea > eb;
        return a < b;
    endfunction

    function automatic void squeeze_page();
        int unsigned order [MAX_SLOTS];
        int unsigned new_off [MAX_SLOTS];
        int unsigned new_len [MAX_SLOTS];
        bit          new_dead [MAX_SLOTS];
        int unsigned gap, last, live, k, v, dst, src;
        gap  = 0;
        last = PAGE_BYTES;
        live = 0;
        compactions++;
        for (int i = 0; i < n_slots; i++)
        begin
            v = i;
            k = i;
            while (k > 0 && walk_first(v, order[k-1]))
            begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = v;
        end
        for (int j = 0; j < n_slots; j++)
        begin
            src = rec_off[order[j]];
            new_len[j]  = rec_len[order[j]];
            new_dead[j] = rec_dead[order[j]];
            if (new_dead[j])
            begin
                gap += new_len[j];
                new_off[j] = src;
            end
            else
            begin
                dst = src + gap;
                // slides only upward, so copy from the top byte down
                for (int b = int'(new_len[j]) - 1; b >= 0; b--)
                begin
                    page_byte[dst+b]  = page_byte[src+b];
                    page_known[dst+b] = page_known[src+b];
                end
                new_off[j] = dst;
                last = dst;
            end
        end
        for (int j = 0; j < n_slots; j++)
            if (!new_dead[j])
            begin
                rec_off[live]  = new_off[j];
                rec_len[live]  = new_len[j];
                rec_dead[live] = 1'b0;
                live++;
            end
        n_slots    = live;
        n_tombs    = 0;
        dead_bytes = 0;
        fs_ptr     = HEADER_BYTES + live * SLOT_BYTES;
        fe_ptr     = last;
    endfunction

    function automatic result_t apply_op(item_t it);
        result_t     r;
        status_t     st;
        int unsigned sn, len, idx, slot, start, total, addr;
        r   = '0;
        st  = ST_OK;
        sn  = 32'(it.slot_number);
        len = 32'(it.record_length);
        idx = 32'(it.byte_index);
        slot = 0;
        case (kind_t'(it.kind))
            K_RESET:
                page_clear();
            K_INSERT:
                if (!place_record(len, slot))
                begin
                    total = (fe_ptr - fs_ptr) + dead_bytes;
                    slot = 0;
                    st = ST_NO_SPACE;
                    if (auto_cmp && len + SLOT_BYTES <= total)
                    begin
                        squeeze_page();
                        if (place_record(len, slot))
                            st = ST_OK;
                        else
                            slot = 0;
                    end
                end
            K_WRITE, K_READ:
                if (!slot_is_live(sn))
                    st = ST_NO_SLOT;
                else if (idx >= rec_len[sn])
                    st = ST_BAD_IDX;
                else
                begin
                    addr = rec_off[sn] + idx;
                    if (it.kind == K_WRITE)
                    begin
                        page_byte[addr]  = it.data_byte;
                        page_known[addr] = 1'b1;
                    end
                    else
                        r.data_out = page_byte[addr];
                end
            K_DELETE:
                if (!slot_is_live(sn))
                    st = ST_NO_SLOT;
                else
                begin
                    rec_dead[sn] = 1'b1;
                    n_tombs++;
                    dead_bytes += rec_len[sn];
                end
            K_UPDATE:
                if (!slot_is_live(sn))
                    st = ST_NO_SLOT;
                else if (len > rec_len[sn])
                begin
                    if (!find_space(len, start))
                        st = ST_NO_SPACE;
                    else
                    begin
                        // old space stays behind as a tombstone in a fresh slot
                        rec_off[n_slots]  = rec_off[sn];
                        rec_len[n_slots]  = rec_len[sn];
                        rec_dead[n_slots] = 1'b1;
                        n_tombs++;
                        dead_bytes += rec_len[sn];
                        n_slots++;
                        rec_off[sn] = start;
                        rec_len[sn] = len;
                        fs_ptr = HEADER_BYTES + n_slots * SLOT_BYTES;
                        fe_ptr = start;
                    end
                end
            K_COMPACT:
                squeeze_page();
            default: ;
        endcase
        r.status           = st;
        r.slot_out         = slot[9:0];
        r.live_records     = 11'(n_slots - n_tombs);
        r.slot_count       = 11'(n_slots);
        r.contiguous_free  = 13'(fe_ptr >= fs_ptr ? fe_ptr - fs_ptr : 0);
        r.needs_compaction = n_slots != 0 && n_tombs > n_slots / 4;
        return r;
    endfunction

    function automatic int unsigned wait_draw(bit busy_free);
        return busy_free ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic item_t mk_item(kind_t k, int sn, int len, int idx, int data);
        item_t it;
        it.kind          = k;
        it.slot_number   = sn[9:0];
        it.record_length = len[12:0];
        it.byte_index    = idx[11:0];
        it.data_byte     = data[7:0];
        return it;
    endfunction

    function automatic void add_row(item_t it, bit typed = 0, status_t st = ST_OK);
        dir_row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = '0;
        if (typed)
        begin
            // empty page after reset
            row.want.status          = st;
            row.want.contiguous_free = 13'(PAGE_BYTES - HEADER_BYTES);
        end
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic int unsigned pick_live();
        int unsigned s;
        for (int t = 0; t < 8; t++)
        begin
            s = $urandom_range(0, n_slots - 1);
            if (slot_is_live(s))
                return s;
        end
        return n_slots;
    endfunction

    function automatic item_t rand_item();
        item_t       it;
        int unsigned sel, s, ix, len;
        it = mk_item(K_QUERY, $urandom_range(0, 1023), $urandom_range(0, 4096),
                     $urandom_range(0, 4095), $urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 2)
            it.kind = K_RESET;
        else if (sel < 5)
            it.kind = K_COMPACT;
        else if (sel < 8)
            it.kind = K_QUERY;
        else if (sel < 13)
        begin
            // noise: whatever slot and index the fields allow
            it.kind = kind_t'($urandom_range(K_WRITE, K_UPDATE));
            s = 32'(it.slot_number);
            // but never a read of a reserved byte that holds no written data
            if (it.kind == K_READ && slot_is_live(s) && it.byte_index < rec_len[s]
                && !page_known[rec_off[s] + it.byte_index])
                it.kind = K_QUERY;
        end
        else if (sel < 38)
        begin
            it.kind = K_INSERT;
            len = $urandom_range(0, 99);
            if (len < 55)
                it.record_length = 13'($urandom_range(1, 64));
            else if (len < 90)
                it.record_length = 13'($urandom_range(150, 600));
            else if (len < 95)
                it.record_length = '0;
            else
                it.record_length = 13'($urandom_range(3000, 4096));
        end
        else if (n_slots == 0)
            it.kind = K_INSERT;
        else
        begin
            s = pick_live();
            it.slot_number = s[9:0];
            if (sel < 60)
            begin
                it.kind = K_WRITE;
                if (s < n_slots && rec_len[s] > 0)
                begin
                    ix = $urandom_range(0, rec_len[s] > 8 ? 7 : rec_len[s] - 1);
                    if ($urandom_range(0, 3) == 0)
                        ix = $urandom_range(0, rec_len[s] - 1);
                    it.byte_index = ix[11:0];
                end
            end
            else if (sel < 80)
            begin
                it.kind = K_READ;
                it.byte_index = 12'hfff;
                for (int t = 0; t < 8 && s < n_slots; t++)
                begin
                    ix = $urandom_range(0, 7);
                    if (ix < rec_len[s] && page_known[rec_off[s] + ix])
                    begin
                        it.byte_index = ix[11:0];
                        break;
                    end
                end
                // never read a reserved byte that holds no written data
                if (s < n_slots && it.byte_index < rec_len[s]
                    && !page_known[rec_off[s] + it.byte_index])
                    it.byte_index = 12'hfff;
                if (s < n_slots && rec_len[s] == 4096)
                    it.kind = K_QUERY;
            end
            else if (sel < 90)
                it.kind = K_DELETE;
            else
            begin
                it.kind = K_UPDATE;
                if (s < n_slots)
                    it.record_length = 13'($urandom_range(0, 1) ? rec_len[s] / 2
                                           : rec_len[s] + $urandom_range(1, 80));
            end
        end
        return it;
    endfunction

    // caller sits just after a rising edge; returns after transfer and idle gap
    task automatic send_op(item_t it, bit typed = 0, result_t want = '0);
        result_t r;
        int unsigned gap;
        cmd.valid   <= 1'b1;
        cmd.payload <= it;
        do @(posedge clk); while (!cmd.ready);
        r = apply_op(it);
        expected_q.insert(expected_q.size(), typed ? want : r);
        items_sent++;
        gap = wait_draw(sender_busy_free);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        cmd.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(bit on);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= on;
        @(posedge clk);
        auto_cmp = on;
        cfg_write_en <= 1'b0;
    endtask

    function automatic void compare_result(result_t got);
        result_t want;
        string   bad;
        if (expected_q.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("[%0t] unexpected result %p", $realtime, got);
            return;
        end
        want = expected_q.pop_front();
        bad = "";
        if (got.status !== want.status)                     bad = {bad, " status"};
        if (got.slot_out !== want.slot_out)                 bad = {bad, " slot_out"};
        if (got.data_out !== want.data_out)                 bad = {bad, " data_out"};
        if (got.live_records !== want.live_records)         bad = {bad, " live_records"};
        if (got.slot_count !== want.slot_count)             bad = {bad, " slot_count"};
        if (got.contiguous_free !== want.contiguous_free)   bad = {bad, " contiguous_free"};
        if (got.needs_compaction !== want.needs_compaction) bad = {bad, " needs_compaction"};
        if (bad != "")
        begin
            err_count++;
            if (err_count <= 10)
                $display("[%0t] mismatch in%s: expected %p, got %p",
                         $realtime, bad, want, got);
        end
    endfunction

    // result side: its own random stall per transfer
    initial
    begin
        int unsigned stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = wait_draw(receiver_busy_free);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
            results_seen++;
            compare_result(res.payload);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("slotted_page_record_store_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        cmd.valid      = 1'b0;
        cmd.payload    = '0;
        items_sent     = 0;
        compactions    = 0;
        auto_cmp       = 1'b1;
        sender_busy_free   = 1'b0;
        receiver_busy_free = 1'b0;
        page_clear();

        add_row(mk_item(K_QUERY,   0,    0,    0,    0), 1, ST_OK);
        add_row(mk_item(K_READ,    0,    0,    0,    0), 1, ST_NO_SLOT);
        add_row(mk_item(K_DELETE,  1023, 0,    4095, 255), 1, ST_NO_SLOT);
        add_row(mk_item(K_INSERT,  0,    4096, 0,    0), 1, ST_NO_SPACE);
        add_row(mk_item(K_INSERT,  1023, 0,    4095, 255));
        add_row(mk_item(K_INSERT,  0,    10,   0,    0));
        add_row(mk_item(K_WRITE,   1,    0,    0,    255));
        add_row(mk_item(K_WRITE,   1,    0,    9,    0));
        add_row(mk_item(K_WRITE,   1,    0,    10,   85));
        add_row(mk_item(K_WRITE,   0,    0,    0,    85));
        add_row(mk_item(K_READ,    1,    0,    0,    0));
        add_row(mk_item(K_READ,    1,    0,    9,    0));
        add_row(mk_item(K_READ,    1,    0,    4095, 0));
        add_row(mk_item(K_DELETE,  0,    0,    0,    0));
        add_row(mk_item(K_DELETE,  0,    0,    0,    0));
        add_row(mk_item(K_UPDATE,  1,    5,    0,    0));
        add_row(mk_item(K_UPDATE,  1,    20,   0,    0));
        add_row(mk_item(K_WRITE,   1,    0,    19,   165));
        add_row(mk_item(K_READ,    1,    0,    19,   0));
        add_row(mk_item(K_UPDATE,  1023, 4096, 0,    0));
        add_row(mk_item(K_COMPACT, 0,    0,    0,    0));
        add_row(mk_item(K_READ,    0,    0,    19,   0));
        add_row(mk_item(K_INSERT,  0,    4000, 0,    0));
        add_row(mk_item(K_RESET,   0,    0,    0,    0));
        add_row(mk_item(K_QUERY,   682,  0,    2730, 170), 1, ST_OK);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_mode(p % 2 == 0 ? 1'b0 : 1'b1);
            sender_busy_free   = (p == 2);
            receiver_busy_free = (p == 2 || p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the page go quiet once mid-phase, then resume
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_op(rand_item());
            end
        end
        drain_results();
        repeat (50) @(posedge clk);

        $display("%0d operations sent, %0d results checked, %0d page compactions",
                 items_sent, results_seen, compactions);
        $display("auto-compaction toggled across %0d phases, with and without stalls",
                 PHASES);
        if (err_count == 0 && expected_q.size() == 0)
            $display("slotted_page_record_store_tb: clean");
        else
            $display("slotted_page_record_store_tb: errors");
        $finish;
    end

endmodule
